@@ sv/bqn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bqn_pkg;

	// Coefficient registers: signed fixed point
	localparam int COEF_WIDTH = 18;
	localparam int CFG_INDEX_WIDTH = 2;

	typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
	typedef logic signed [COEF_WIDTH-1:0] coef_t;

	localparam cfg_index_t REG_COEF_B1 = 2'd0;
	localparam cfg_index_t REG_COEF_A1 = 2'd1;
	localparam cfg_index_t REG_COEF_A2 = 2'd2;

	// 50 Hz notch at 500 Hz sampling, pole radius 0.99
	localparam coef_t COEF_B1_RESET = -18'sd26509;
	localparam coef_t COEF_A1_RESET = 18'sd26245;
	localparam coef_t COEF_A2_RESET = 18'sd16058;

endpackage

`default_nettype wire

@@ sv/biquad_notch_filter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Second-order IIR notch filter, numerator (1, b1, 1), computing
// y = x + b1*x1 + x2 + a1*y1 - a2*y2 per sample. Each input transaction carries one
// signed sample in s_axis_tdata and a restart flag in s_axis_tuser; each output
// transaction carries one filtered sample in m_axis_tdata and a saturation flag in
// m_axis_tuser. The block takes one sample per clock cycle unless the output is stalled
// by m_axis_tready; each sample passes the input register, then the result register.
// The new history value is formed combinationally by five multipliers and one
// adder tree from the input register and the history registers, then written back
// together with the result register. The first sample after reset, or
// any sample with restart set, primes the whole history with that sample and passes it
// through unchanged. Feedback history keeps HISTORY_WIDTH bits with COEF_FRAC_BITS
// fraction bits and wraps on overflow; the output is truncated toward zero and
// saturated to SAMPLE_WIDTH bits. Coefficients are written through the cfg port
// (index 0: b1, 1: a1, 2: a2; other indexes are ignored) and may only change while
// no sample is in flight. cfg_ready is always high.
module biquad_notch_filter_unit #(
	parameter int COEF_FRAC_BITS = 14,
	parameter int SAMPLE_WIDTH = 16,
	parameter int HISTORY_WIDTH = 40
) (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [bqn_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [bqn_pkg::COEF_WIDTH-1:0] cfg_data,

	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// [SAMPLE_WIDTH-1:0] sample_in, zero padding above
	input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// [0] restart
	input  wire logic s_axis_tuser,

	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// [SAMPLE_WIDTH-1:0] sample_out, zero padding above
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// [0] saturated
	output logic m_axis_tuser
);

	import bqn_pkg::*;

	localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int F = COEF_FRAC_BITS;
	localparam int SW = SAMPLE_WIDTH;
	localparam int HW = HISTORY_WIDTH;
	localparam int YH_W = HW - F;
	// Wide enough for every term before wrapping to the history width
	localparam int TW = HW + COEF_WIDTH + SW + 2;
	// Quotient width for the saturation compare
	localparam int EW = ((YH_W > SW) ? YH_W : SW) + 1;
	localparam logic signed [EW-1:0] SMAX = EW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] SMIN = EW'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

	// Coefficient registers
	coef_t coef_b1_q, coef_a1_q, coef_a2_q;

	// Input stage
	logic valid_s1;
	logic signed [SW-1:0] sample_s1;
	logic restart_s1;

	// Filter history
	logic signed [SW-1:0] prev_in_1_q, prev_in_2_q;
	logic signed [HW-1:0] prev_out_1_q, prev_out_2_q;
	logic primed_q;

	// Result register
	logic out_valid_q;
	logic [SW-1:0] out_sample_q;
	logic out_sat_q;

	logic out_free;
	logic adv_s1;
	logic prime;

	logic signed [SW:0] in_sum;
	logic signed [COEF_WIDTH+SW-1:0] prod_b1;
	logic signed [YH_W-1:0] yh1, yh2;
	logic signed [F:0] yl1, yl2;
	logic signed [COEF_WIDTH+YH_W-1:0] prod_h1, prod_h2;
	logic signed [COEF_WIDTH+F:0] prod_l1, prod_l2;
	logic signed [TW-1:0] term_x, term_b1, term_a1, term_a2, acc, prime_wide;
	logic signed [HW-1:0] yn, prime_hist;
	logic signed [YH_W-1:0] q_floor, q_trunc;
	logic signed [EW-1:0] q_ext;
	logic sat_pos, sat_neg;
	logic [SW-1:0] res_sample;
	logic res_sat;

	assign cfg_ready = 1'b1;

	// Handshake: result register frees when empty or being taken
	assign out_free = !out_valid_q || m_axis_tready;
	assign adv_s1 = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = DATA_W'(out_sample_q);
	assign m_axis_tuser = out_sat_q;

	assign prime = restart_s1 || !primed_q;

	// Feed-forward part: (x + x2) scaled, plus b1*x1 exact
	assign in_sum = {sample_s1[SW-1], sample_s1} + {prev_in_2_q[SW-1], prev_in_2_q};
	assign term_x = TW'(in_sum) <<< F;
	assign prod_b1 = coef_b1_q * prev_in_1_q;
	assign term_b1 = TW'(prod_b1);

	// Feedback part: floor(c*y / 2^F) split into high and low halves of y
	assign yh1 = prev_out_1_q[HW-1:F];
	assign yl1 = {1'b0, prev_out_1_q[F-1:0]};
	assign yh2 = prev_out_2_q[HW-1:F];
	assign yl2 = {1'b0, prev_out_2_q[F-1:0]};
	assign prod_h1 = coef_a1_q * yh1;
	assign prod_l1 = coef_a1_q * yl1;
	assign prod_h2 = coef_a2_q * yh2;
	assign prod_l2 = coef_a2_q * yl2;
	assign term_a1 = TW'(prod_h1) + TW'(prod_l1 >>> F);
	assign term_a2 = TW'(prod_h2) + TW'(prod_l2 >>> F);

	assign acc = term_x + term_b1 + term_a1 - term_a2;
	// Wrap to the history width
	assign yn = acc[HW-1:0];

	assign prime_wide = TW'(sample_s1) <<< F;
	assign prime_hist = prime_wide[HW-1:0];

	// Truncate toward zero: bump the floored quotient of a negative with a remainder
	assign q_floor = yn[HW-1:F];
	assign q_trunc = q_floor + YH_W'(yn[HW-1] && (|yn[F-1:0]));
	assign q_ext = EW'(q_trunc);
	assign sat_pos = q_ext > SMAX;
	assign sat_neg = q_ext < SMIN;

	always_comb begin
		priority if (prime) begin
			res_sample = sample_s1;
			res_sat = 1'b0;
		end else if (sat_pos) begin
			res_sample = SMAX[SW-1:0];
			res_sat = 1'b1;
		end else if (sat_neg) begin
			res_sample = SMIN[SW-1:0];
			res_sat = 1'b1;
		end else begin
			res_sample = q_ext[SW-1:0];
			res_sat = 1'b0;
		end
	end

	// Coefficient writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b1_q <= COEF_B1_RESET;
			coef_a1_q <= COEF_A1_RESET;
			coef_a2_q <= COEF_A2_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COEF_B1: coef_b1_q <= cfg_data;
				REG_COEF_A1: coef_a1_q <= cfg_data;
				REG_COEF_A2: coef_a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= s_axis_tdata[SW-1:0];
			restart_s1 <= s_axis_tuser;
		end
	end

	// History and priming flag advance with each processed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_in_1_q <= '0;
			prev_in_2_q <= '0;
			prev_out_1_q <= '0;
			prev_out_2_q <= '0;
			primed_q <= 1'b0;
		end else if (adv_s1) begin
			primed_q <= 1'b1;
			if (prime) begin
				prev_in_1_q <= sample_s1;
				prev_in_2_q <= sample_s1;
				prev_out_1_q <= prime_hist;
				prev_out_2_q <= prime_hist;
			end else begin
				prev_in_2_q <= prev_in_1_q;
				prev_in_1_q <= sample_s1;
				prev_out_2_q <= prev_out_1_q;
				prev_out_1_q <= yn;
			end
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_sample_q <= res_sample;
			out_sat_q <= res_sat;
		end
	end

	// A processed sample always leaves the filter primed
	a_primed_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> primed_q)
		else $error("filter not primed after a processed sample");

	// A clamped result sits exactly on one of the limits
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_sat_q) |->
		(out_sample_q == SMAX[SW-1:0] || out_sample_q == SMIN[SW-1:0]))
		else $error("saturated result not at a limit");

	// A priming sample passes through unchanged and unclamped
	a_prime_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && prime) |=> (out_sample_q == $past(sample_s1) && !out_sat_q))
		else $error("priming sample not passed through");

	// Input stage stalls only while holding a sample that cannot move on
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without cause");

endmodule

`default_nettype wire

@@ tb/biquad_notch_filter_unit_test.sv @@
`timescale 1ns / 1ps

module biquad_notch_filter_unit_test;

	import bqn_pkg::*;

	localparam int FRAC_BITS = 14;
	localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;
	localparam longint SAMPLE_MAX = 32767;
	localparam longint SAMPLE_MIN = -32768;
	localparam int RAND_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 150;

	// Index 3 decodes to no register; writes there must change nothing
	localparam cfg_index_t REG_UNUSED = 2'd3;
	localparam coef_t COEF_MAX = coef_t'(18'h1FFFF);
	localparam coef_t COEF_MIN = coef_t'(18'h20000);

	typedef struct packed {
		logic [15:0] sample;
		logic restart;
	} sample_item_t;

	typedef struct packed {
		logic [15:0] sample;
		logic sat;
	} filtered_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_index_t cfg_index = REG_COEF_B1;
	coef_t cfg_data = '0;

	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [15:0] sample_in
	logic s_axis_tuser = 1'b0;       // [0] restart

	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;       // [15:0] sample_out
	logic m_axis_tuser;              // [0] saturated

	biquad_notch_filter_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #10 clk = ~clk;

	// Shadow copy of the coefficient registers and of the filter history
	coef_t shadow_b1 = COEF_B1_RESET;
	coef_t shadow_a1 = COEF_A1_RESET;
	coef_t shadow_a2 = COEF_A2_RESET;
	logic signed [15:0] hist_x1 = '0;
	logic signed [15:0] hist_x2 = '0;
	logic signed [39:0] hist_y1 = '0;
	logic signed [39:0] hist_y2 = '0;
	bit hist_primed = 1'b0;

	sample_item_t pending_samples[$];
	filtered_t expected_outputs[$];
	int mismatch_count = 0;

	// Idle and stall probabilities in percent, changed per phase
	int gap_pct = 0;
	int stall_pct = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s, got %0d, want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Advance the notch filter by one sample and return the output transaction it gives
	function automatic filtered_t notch_predict(input logic signed [15:0] x, input bit restart);
		longint acc;
		longint fb1;
		longint fb2;
		longint q;
		logic signed [39:0] y_new;
		filtered_t res;
		if (!hist_primed || restart) begin
			// Prime the whole history with this sample and pass it through
			acc = longint'(x) * FRAC_ONE;
			hist_x1 = x;
			hist_x2 = x;
			hist_y1 = acc[39:0];
			hist_y2 = acc[39:0];
			hist_primed = 1'b1;
			res.sample = x;
			res.sat = 1'b0;
			return res;
		end
		// Feedback products are floored to the history's fraction bits
		fb1 = (longint'(shadow_a1) * longint'(hist_y1)) >>> FRAC_BITS;
		fb2 = (longint'(shadow_a2) * longint'(hist_y2)) >>> FRAC_BITS;
		acc = (longint'(x) + longint'(hist_x2)) * FRAC_ONE
			+ longint'(shadow_b1) * longint'(hist_x1) + fb1 - fb2;
		y_new = acc[39:0];  // history wraps, never clamps
		hist_x2 = hist_x1;
		hist_x1 = x;
		hist_y2 = hist_y1;
		hist_y1 = y_new;
		// Truncate toward zero, then clamp to the sample range
		q = longint'(y_new) / FRAC_ONE;
		res.sat = 1'b0;
		if (q > SAMPLE_MAX) begin
			q = SAMPLE_MAX;
			res.sat = 1'b1;
		end else if (q < SAMPLE_MIN) begin
			q = SAMPLE_MIN;
			res.sat = 1'b1;
		end
		res.sample = q[15:0];
		return res;
	endfunction

	// Input side: predict on every accepted transaction, then present the next item
	int send_gap = 0;
	sample_item_t in_flight = '0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_outputs.push_back(notch_predict(in_flight.sample, in_flight.restart));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_samples.size() != 0 && $urandom_range(99) < gap_pct) begin
					// Open an idle burst
					send_gap = $urandom_range(7);
					s_axis_tvalid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					in_flight = pending_samples.pop_front();
					s_axis_tdata <= in_flight.sample;
					s_axis_tuser <= in_flight.restart;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: check each accepted transaction, stall in random bursts
	int hold_cnt = 0;

	always @(posedge clk) begin
		filtered_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_outputs.size() == 0) begin
					report_mismatch("unexpected sample_out", $signed(m_axis_tdata), 0);
				end else begin
					want = expected_outputs.pop_front();
					if (m_axis_tdata !== want.sample)
						report_mismatch("sample_out", $signed(m_axis_tdata),
							$signed(want.sample));
					if (m_axis_tuser !== want.sat)
						report_mismatch("saturated", m_axis_tuser, want.sat);
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(99) < stall_pct) begin
				hold_cnt = $urandom_range(7);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Wait until every queued sample went in and every result came out
	task automatic wait_drained();
		@(negedge clk);
		while (pending_samples.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write b1, a1, a2, plus index 3 on poke_unused, back to back; valid stays high
	task automatic load_coefs(input coef_t b1, input coef_t a1, input coef_t a2,
			input bit poke_unused);
		cfg_index_t idx[$];
		coef_t val[$];
		idx.push_back(REG_COEF_B1);
		val.push_back(b1);
		idx.push_back(REG_COEF_A1);
		val.push_back(a1);
		idx.push_back(REG_COEF_A2);
		val.push_back(a2);
		if (poke_unused) begin
			idx.push_back(REG_UNUSED);
			val.push_back(coef_t'($urandom));
		end
		@(posedge clk);
		foreach (idx[i]) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx[i])
				REG_COEF_B1: shadow_b1 = val[i];
				REG_COEF_A1: shadow_a1 = val[i];
				REG_COEF_A2: shadow_a2 = val[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_sample(input logic [15:0] sample, input bit restart);
		sample_item_t item;
		item.sample = sample;
		item.restart = restart;
		pending_samples.push_back(item);
	endtask

	// Mostly full-range noise, some extremes and some low-level signal
	function automatic logic [15:0] random_sample();
		case ($urandom_range(9))
			0: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			1, 2: return 16'($urandom_range(400) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		coef_t b1;
		coef_t a1;
		coef_t a2;
		int r_q14;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset coefficients: first sample primes without restart, then full-scale
		// alternation near Nyquist to push the output into the clamp
		gap_pct = 20;
		stall_pct = 20;
		queue_sample(16'h7FFF, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h7FFF, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h7FFF, 1'b0);
		queue_sample(16'h0000, 1'b0);
		queue_sample(16'h0001, 1'b0);
		queue_sample(16'hFFFF, 1'b0);
		queue_sample(16'h5555, 1'b0);
		queue_sample(16'hAAAA, 1'b0);
		queue_sample(16'h8000, 1'b1);
		queue_sample(16'h7FFF, 1'b1);
		queue_sample(16'h0000, 1'b0);
		wait_drained();

		// Extreme coefficients: history grows until it wraps
		load_coefs(COEF_MAX, COEF_MAX, COEF_MIN, 1'b1);
		queue_sample(16'd12345, 1'b1);
		repeat (4) queue_sample(16'h7FFF, 1'b0);
		repeat (3) queue_sample(16'h8000, 1'b0);
		queue_sample(16'h0000, 1'b0);
		queue_sample(16'h7FFF, 1'b1);
		wait_drained();

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin
					b1 = COEF_MIN;
					a1 = COEF_MIN;
					a2 = COEF_MIN;
				end
				1: begin
					b1 = COEF_MAX;
					a1 = COEF_MAX;
					a2 = COEF_MAX;
				end
				2: begin
					b1 = '0;
					a1 = '0;
					a2 = '0;
				end
				3: begin
					b1 = COEF_B1_RESET;
					a1 = COEF_A1_RESET;
					a2 = COEF_A2_RESET;
				end
				default: begin
					if (p % 2 == 0) begin
						// Stable notch: a2 = r^2, a1 = -r*b1 with r from the mean of 1 and r^2
						b1 = coef_t'($urandom_range(65535) - 32768);
						a2 = coef_t'($urandom_range(13000, 16300));
						r_q14 = (16384 + int'(a2)) / 2;
						a1 = coef_t'(-((int'(b1) * r_q14) >>> FRAC_BITS));
					end else begin
						b1 = coef_t'($urandom);
						a1 = coef_t'($urandom);
						a2 = coef_t'($urandom);
					end
				end
			endcase
			load_coefs(b1, a1, a2, $urandom_range(3) == 0);

			// Drop idling entirely in the last phase
			if (p == RAND_PHASES - 1) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(2))
					0: gap_pct = 0;
					1: gap_pct = 15;
					default: gap_pct = 40;
				endcase
				case ($urandom_range(2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 40;
				endcase
			end

			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				queue_sample(random_sample(), $urandom_range(39) == 0);
			wait_drained();
		end

		// Let any stray result surface before judging
		repeat (8) @(posedge clk);
		if (expected_outputs.size() != 0)
			report_mismatch("results never delivered", 0, expected_outputs.size());
		if (mismatch_count == 0) begin
			$display("[biquad_notch_filter_unit] OK");
		end else begin
			$display("[biquad_notch_filter_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#6_000_000;
		$display("[biquad_notch_filter_unit] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
sv/bqn_pkg.sv
sv/biquad_notch_filter_unit.sv
tb/biquad_notch_filter_unit_test.sv
